[sv/ipfl_pkg.sv]
// ----------------------------------------------------------------------------
// ipfl_pkg: shared types and constants
// Request and result payloads, opcodes, status codes and the command and
// status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package ipfl_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register indexes (word address bits of paddr)
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [8:0] CAP_RESET = 9'd256;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EMPTY        = 2'd1;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [1:0] ST_RANGE        = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] block_index;
	} req_t;

	typedef struct packed {
		logic [7:0] granted_index;
		logic [1:0] status;
		logic [8:0] live_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_POP,
		ACT_POP_FIN,
		ACT_FRESH,
		ACT_PUSH,
		ACT_CLEAR,
		ACT_REPORT
	} act_t;

	typedef struct packed {
		act_t       act;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       head_empty;
		logic       fresh_avail;
		logic       range_ok;
		logic       marked;
	} stat_t;

endpackage

[sv/ipfl_cfg.sv]
// ----------------------------------------------------------------------------
// ipfl_cfg: configuration register port
// APB-style access to the capacity register; pready is tied high.
// ----------------------------------------------------------------------------
module ipfl_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipfl_pkg::ADDR_W-1:0]  paddr,
	input  logic [ipfl_pkg::DATA_W-1:0]  pwdata,
	output logic [ipfl_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [8:0]                   capacity
);

	logic [8:0] capacity_q;
	logic       sel_cap;

	assign pready  = 1'b1;
	assign sel_cap = (paddr[ipfl_pkg::ADDR_W-1] == ipfl_pkg::REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ipfl_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			capacity_q <= pwdata[8:0];
		end
	end

	assign prdata   = sel_cap ? {{(ipfl_pkg::DATA_W-9){1'b0}}, capacity_q}
	                          : '0;
	assign capacity = capacity_q;

endmodule

[sv/ipfl_ctrl.sv]
// ----------------------------------------------------------------------------
// ipfl_ctrl: request controller
// Decodes each request against the pool status and sequences the list pop
// through its link memory read state; owns the result valid flag.
// ----------------------------------------------------------------------------
module ipfl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  ipfl_pkg::stat_t  stat,
	output ipfl_pkg::cmd_t   cmd
);

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;

	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.act  = ipfl_pkg::ACT_NONE;
		cmd.code = ipfl_pkg::ST_OK;
		if (state_q == S_READ) begin
			cmd.act = ipfl_pkg::ACT_POP_FIN;
		end else if (accept) begin
			unique case (stat.opcode)
				ipfl_pkg::OP_ALLOC: begin
					// list first, then the fresh range
					priority if (!stat.head_empty) begin
						cmd.act = ipfl_pkg::ACT_POP;
					end else if (stat.fresh_avail) begin
						cmd.act = ipfl_pkg::ACT_FRESH;
					end else begin
						cmd.act  = ipfl_pkg::ACT_REPORT;
						cmd.code = ipfl_pkg::ST_EMPTY;
					end
				end
				ipfl_pkg::OP_FREE: begin
					// range check wins over the double free check
					priority if (!stat.range_ok) begin
						cmd.act  = ipfl_pkg::ACT_REPORT;
						cmd.code = ipfl_pkg::ST_RANGE;
					end else if (!stat.marked) begin
						cmd.act  = ipfl_pkg::ACT_REPORT;
						cmd.code = ipfl_pkg::ST_ALREADY_FREE;
					end else begin
						cmd.act = ipfl_pkg::ACT_PUSH;
					end
				end
				ipfl_pkg::OP_RESET: begin
					cmd.act = ipfl_pkg::ACT_CLEAR;
				end
				default: begin
					cmd.act = ipfl_pkg::ACT_REPORT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (cmd.act)
				ipfl_pkg::ACT_NONE: begin
				end
				ipfl_pkg::ACT_POP: begin
					state_q <= S_READ;
				end
				ipfl_pkg::ACT_POP_FIN: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				default: begin
					rsp_valid_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

[sv/ipfl_dp.sv]
// ----------------------------------------------------------------------------
// ipfl_dp: pool datapath
// Free list head, link memory, watermark, in-use flags, live count and the
// result register, all updated under controller commands.
// ----------------------------------------------------------------------------
module ipfl_dp #(
	parameter int POOL_CAPACITY = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ipfl_pkg::req_t   req,
	input  logic [8:0]       capacity,
	input  ipfl_pkg::cmd_t   cmd,
	output ipfl_pkg::stat_t  stat,
	output ipfl_pkg::rsp_t   rsp
);

	// indices reachable through the 9-bit capacity register
	localparam int DEPTH = (POOL_CAPACITY < 511) ? POOL_CAPACITY : 511;
	// only indices below 256 can ever be freed, so only those need flags and links
	localparam int MARKS = (DEPTH < 256) ? DEPTH : 256;
	localparam int MW    = $clog2(MARKS);

	logic [8:0]       head_q;
	logic [8:0]       fresh_q;
	logic [8:0]       active_q;
	logic [MARKS-1:0] in_use_q;
	logic [8:0]       link_mem [MARKS];
	logic [8:0]       link_rd_q;
	ipfl_pkg::rsp_t   rsp_q;

	logic [8:0]    eff_cap;
	logic [8:0]    head_dec;
	logic [MW-1:0] pop_addr;
	logic [MW-1:0] idx_addr;
	logic [MW-1:0] fresh_addr;
	logic          fresh_flagged;
	logic [8:0]    active_nxt;

	assign eff_cap       = (capacity > 9'(DEPTH)) ? 9'(DEPTH) : capacity;
	assign head_dec      = head_q - 9'd1;
	assign pop_addr      = head_dec[MW-1:0];
	assign idx_addr      = req.block_index[MW-1:0];
	assign fresh_addr    = fresh_q[MW-1:0];
	assign fresh_flagged = (fresh_q < 9'(MARKS));

	assign stat.opcode      = req.opcode;
	assign stat.head_empty  = (head_q == 9'd0);
	assign stat.fresh_avail = (fresh_q < eff_cap);
	assign stat.range_ok    = ({1'b0, req.block_index} < eff_cap);
	assign stat.marked      = stat.range_ok && in_use_q[idx_addr];

	always_comb begin
		unique case (cmd.act)
			ipfl_pkg::ACT_POP,
			ipfl_pkg::ACT_FRESH: active_nxt = active_q + 9'd1;
			ipfl_pkg::ACT_PUSH:  active_nxt = (active_q != 9'd0) ? active_q - 9'd1 : active_q;
			ipfl_pkg::ACT_CLEAR: active_nxt = 9'd0;
			default:             active_nxt = active_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= 9'd0;
			fresh_q  <= 9'd0;
			active_q <= 9'd0;
			in_use_q <= '0;
		end else begin
			active_q <= active_nxt;
			unique case (cmd.act)
				ipfl_pkg::ACT_POP: begin
					in_use_q[pop_addr] <= 1'b1;
				end
				ipfl_pkg::ACT_POP_FIN: begin
					head_q <= link_rd_q;
				end
				ipfl_pkg::ACT_FRESH: begin
					fresh_q <= fresh_q + 9'd1;
					if (fresh_flagged) begin
						in_use_q[fresh_addr] <= 1'b1;
					end
				end
				ipfl_pkg::ACT_PUSH: begin
					head_q             <= {1'b0, req.block_index} + 9'd1;
					in_use_q[idx_addr] <= 1'b0;
				end
				ipfl_pkg::ACT_CLEAR: begin
					head_q   <= 9'd0;
					fresh_q  <= 9'd0;
					in_use_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// link memory: one write port, one registered read port at the list head
	always_ff @(posedge clk) begin
		if (cmd.act == ipfl_pkg::ACT_PUSH) begin
			link_mem[idx_addr] <= head_q;
		end
		link_rd_q <= link_mem[pop_addr];
	end

	// result payload, loaded when the request is taken
	always_ff @(posedge clk) begin
		if (cmd.act != ipfl_pkg::ACT_NONE && cmd.act != ipfl_pkg::ACT_POP_FIN) begin
			rsp_q.status     <= cmd.code;
			rsp_q.live_count <= active_nxt;
			unique case (cmd.act)
				ipfl_pkg::ACT_POP:   rsp_q.granted_index <= head_dec[7:0];
				ipfl_pkg::ACT_FRESH: rsp_q.granted_index <= fresh_q[7:0];
				default:             rsp_q.granted_index <= 8'd0;
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

[sv/index_pool_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Results: a result is valid in the cycle after its request is taken; an allocate
// that pops the free list also waits on the registered link memory read.
// Throughput: one request a cycle unless rsp_stall holds a pending result; no request is taken during a list pop.
// Reset: arst_n clears the list head, watermark, live count and in-use flags.
// ----------------------------------------------------------------------------
module index_pool_free_list_allocator #(
	parameter int POOL_CAPACITY = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  ipfl_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output ipfl_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipfl_pkg::ADDR_W-1:0]  paddr,
	input  logic [ipfl_pkg::DATA_W-1:0]  pwdata,
	output logic [ipfl_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	logic [8:0]      capacity;
	ipfl_pkg::cmd_t  cmd;
	ipfl_pkg::stat_t stat;

	ipfl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	ipfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ipfl_dp #(
		.POOL_CAPACITY (POOL_CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.capacity (capacity),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	// a list pop always completes in the following cycle
	a_pop_completes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ipfl_pkg::ACT_POP |=> cmd.act == ipfl_pkg::ACT_POP_FIN)
		else $error("list pop did not complete");

	// a pool reset reports an empty pool on the next cycle
	a_reset_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.opcode == ipfl_pkg::OP_RESET
		|=> rsp_valid && rsp.live_count == 9'd0 && rsp.status == ipfl_pkg::ST_OK)
		else $error("pool reset result wrong");

	// no new request is taken while a pop waits on the link memory
	a_no_accept_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ipfl_pkg::ACT_POP |=> req_stall)
		else $error("request taken during list pop");

	// only a successful allocate hands out a non-zero index
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ipfl_pkg::ST_OK |-> rsp.granted_index == 8'd0)
		else $error("index granted on failed request");
`endif

endmodule
